// ===== hdl/pstk_pkg.sv =====
// Shared types and constants for the per-slide top-k tracker.
package pstk_pkg;

  localparam int MAX_K_DEF    = 32;
  localparam int VAL_W        = 32;
  localparam int ID_W         = 32;
  localparam int CFG_W        = 6;
  localparam logic [CFG_W-1:0] TOPK_RESET = 6'd8;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_NEW
  } cell_cmd_t;

  typedef struct packed {
    logic gt;
    logic lt;
  } cell_flags_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } pstk_state_t;

endpackage

// ===== hdl/pstk_cell.sv =====
// One cell of the sorted insertion chain: a (value, id) entry and its comparators.
module pstk_cell import pstk_pkg::*; (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic signed [VAL_W-1:0] new_value,
  input  logic        [ID_W-1:0]  new_id,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic        [ID_W-1:0]  left_id,
  input  logic signed [VAL_W-1:0] right_value,
  input  logic        [ID_W-1:0]  right_id,
  output logic signed [VAL_W-1:0] value,
  output logic        [ID_W-1:0]  id,
  output cell_flags_t             flags
);

  logic signed [VAL_W-1:0] value_r;
  logic        [ID_W-1:0]  id_r;

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_HOLD: begin
        value_r <= value_r;
        id_r    <= id_r;
      end
      CMD_LEFT: begin
        value_r <= left_value;
        id_r    <= left_id;
      end
      CMD_RIGHT: begin
        value_r <= right_value;
        id_r    <= right_id;
      end
      CMD_NEW: begin
        value_r <= new_value;
        id_r    <= new_id;
      end
      default: begin
        value_r <= value_r;
        id_r    <= id_r;
      end
    endcase
  end

  assign value    = value_r;
  assign id       = id_r;
  assign flags.gt = (value_r > new_value);
  assign flags.lt = (value_r < new_value);

endmodule

// ===== hdl/per_slide_topk_tracker.sv =====
// Top level of the per-slide top-k tracker: cell chain, fill count and drain control.
//
// Usage: stream words arrive on the in_ channel (valid/stall). A word with
// in_action = 0 is a stream item; it is taken while in_stall is low and yields no
// output. The chain keeps the topk_count largest items of the slide sorted,
// smallest first; every cell compares against the incoming value at once and
// hands its entry to a neighbour in the same cycle.
// A word with in_action = 1 closes the slide: the kept items leave on the out_
// channel smallest first, out_last on the final one. The closing word moves the
// state register to its drain state, from which the head of the chain is loaded
// into the output register, one word a cycle while out_stall is low. During that
// drain in_stall is high, as the chain shifts towards cell 0.
// An empty slide emits nothing.
// A stall on the out_ channel holds the output register; the drain waits.
// The last result word may still wait while new stream items are taken.
// cfg_we/cfg_wdata write topk_count (0 acts as 1, above MAX_K acts as MAX_K);
// write it only while the block is idle.
// Reset (rst_n low, synchronous): the list empties, topk_count returns to 8.
module per_slide_topk_tracker import pstk_pkg::*; #(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_action,
  input  logic signed [VAL_W-1:0] in_item_value,
  input  logic        [ID_W-1:0]  in_item_id,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_value,
  output logic        [ID_W-1:0]  out_id,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic        [CFG_W-1:0] cfg_wdata
);

  localparam int FW = $clog2(MAX_K + 1);
  localparam int KW = (FW > CFG_W) ? FW : CFG_W;

  logic [CFG_W-1:0] topk_r;
  logic [FW-1:0]    fill_count_r, fill_count_nxt;
  pstk_state_t      state_r, state_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r;
  logic        [ID_W-1:0]  out_id_r;
  logic                    out_last_r;

  logic signed [VAL_W-1:0] cell_value [MAX_K];
  logic        [ID_W-1:0]  cell_id    [MAX_K];
  cell_cmd_t               cell_cmd   [MAX_K];
  cell_flags_t             cell_flags [MAX_K];
  logic [MAX_K-1:0]        gt_m, lt_m, at_or_after;

  logic [KW-1:0] eff_k;
  logic          full;
  logic          in_accept;
  logic          ins_fill, ins_full;
  logic          out_load;
  logic          slide_end;

  // Clamp the configured k into 1..MAX_K
  always_comb begin
    priority if (topk_r == '0) begin
      eff_k = KW'(1);
    end else if (KW'(topk_r) > KW'(MAX_K)) begin
      eff_k = KW'(MAX_K);
    end else begin
      eff_k = KW'(topk_r);
    end
  end

  assign full      = (KW'(fill_count_r) >= eff_k);
  assign in_accept = in_valid && !in_stall;
  assign ins_fill  = in_accept && !in_action && !full;
  // Full list: take the item only if it beats the minimum in cell 0
  assign ins_full  = in_accept && !in_action && full && lt_m[0];
  assign slide_end = in_accept && in_action;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topk_r <= TOPK_RESET;
    end else if (cfg_we) begin
      topk_r <= cfg_wdata;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (slide_end && fill_count_r != '0) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_load && fill_count_r == FW'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        out_load = 1'b0;
      end
      ST_DRAIN: begin
        in_stall = 1'b1;
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
        out_load = 1'b0;
      end
    endcase
  end

  // Fill count: grow on a fill insertion, count down while draining
  always_comb begin
    fill_count_nxt = fill_count_r;
    priority if (out_load) begin
      fill_count_nxt = fill_count_r - FW'(1);
    end else if (ins_fill) begin
      fill_count_nxt = fill_count_r + FW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Output register: take the head of the chain
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= cell_value[0];
      out_id_r    <= cell_id[0];
      out_last_r  <= (fill_count_r == FW'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_id    = out_id_r;
  assign out_last  = out_last_r;

  // Cell chain
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic                    occ;
    logic                    left_aa;
    logic                    right_lt;
    logic signed [VAL_W-1:0] left_value, right_value;
    logic        [ID_W-1:0]  left_id, right_id;

    assign occ            = (FW'(i) < fill_count_r);
    assign gt_m[i]        = occ && cell_flags[i].gt;
    assign lt_m[i]        = occ && cell_flags[i].lt;
    // Cell sits at or after the fill-phase insertion point
    assign at_or_after[i] = gt_m[i] || !occ;

    if (i == 0) begin : g_head
      assign left_aa    = 1'b0;
      assign left_value = cell_value[i];
      assign left_id    = cell_id[i];
    end else begin : g_body
      assign left_aa    = at_or_after[i-1];
      assign left_value = cell_value[i-1];
      assign left_id    = cell_id[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign right_lt    = 1'b0;
      assign right_value = cell_value[i];
      assign right_id    = cell_id[i];
    end else begin : g_inner
      assign right_lt    = lt_m[i+1];
      assign right_value = cell_value[i+1];
      assign right_id    = cell_id[i+1];
    end

    always_comb begin
      cell_cmd[i] = CMD_HOLD;
      priority if (out_load) begin
        cell_cmd[i] = CMD_RIGHT;
      end else if (ins_fill) begin
        if (at_or_after[i]) cell_cmd[i] = left_aa ? CMD_LEFT : CMD_NEW;
      end else if (ins_full) begin
        if (lt_m[i]) cell_cmd[i] = right_lt ? CMD_RIGHT : CMD_NEW;
      end
    end

    pstk_cell u_cell (
      .clk         (clk),
      .cmd         (cell_cmd[i]),
      .new_value   (in_item_value),
      .new_id      (in_item_id),
      .left_value  (left_value),
      .left_id     (left_id),
      .right_value (right_value),
      .right_id    (right_id),
      .value       (cell_value[i]),
      .id          (cell_id[i]),
      .flags       (cell_flags[i])
    );
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    KW'(fill_count_r) <= KW'(MAX_K))
    else $error("fill count beyond chain length");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && out_load && fill_count_r == FW'(1)) |=>
      (state_r == ST_IDLE && out_valid && out_last))
    else $error("drain did not finish on last word");

  a_stream_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_action) |=> (fill_count_r >= $past(fill_count_r)))
    else $error("stream item shrank the list");
`endif

endmodule

// ===== tb/topk_slide_checker.sv =====
// Checker for the per-slide top-k tracker: keeps its own sorted list and compares every word out.
module topk_slide_checker import pstk_pkg::*; #(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_action,
  input  logic signed [VAL_W-1:0] in_item_value,
  input  logic        [ID_W-1:0]  in_item_id,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [VAL_W-1:0] out_value,
  input  logic        [ID_W-1:0]  out_id,
  input  logic                    out_last,
  input  logic                    cfg_we,
  input  logic        [CFG_W-1:0] cfg_wdata,
  output int                      mismatches,
  output int                      words_pending
);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic        [ID_W-1:0]  id;
    logic                    last;
  } slide_word_t;

  // Room for one full slide plus the word still waiting in the output register.
  localparam int PEND_DEPTH = 2 * MAX_K;

  logic signed [VAL_W-1:0] list_value [MAX_K];
  logic        [ID_W-1:0]  list_id    [MAX_K];
  int                      list_fill;
  logic        [CFG_W-1:0] topk_setting;
  slide_word_t             pend_words [PEND_DEPTH];
  int                      pend_head;
  int                      pend_count;

  // Zero acts as one, anything above MAX_K saturates.
  function automatic int kept_limit();
    if (topk_setting == '0) return 1;
    if (int'(topk_setting) > MAX_K) return MAX_K;
    return int'(topk_setting);
  endfunction

  task automatic insert_item(input logic signed [VAL_W-1:0] v, input logic [ID_W-1:0] id);
    int pos;
    if (list_fill < kept_limit()) begin
      // still filling: go in after any equal values
      pos = 0;
      while (pos < list_fill && list_value[pos] <= v) pos++;
      for (int i = list_fill; i > pos; i--) begin
        list_value[i] = list_value[i-1];
        list_id[i]    = list_id[i-1];
      end
      list_value[pos] = v;
      list_id[pos]    = id;
      list_fill++;
    end else if (list_fill > 0 && v > list_value[0]) begin
      // full: drop the minimum, go in ahead of any equal values
      pos = 1;
      while (pos < list_fill && list_value[pos] < v) pos++;
      for (int i = 0; i + 1 < pos; i++) begin
        list_value[i] = list_value[i+1];
        list_id[i]    = list_id[i+1];
      end
      list_value[pos-1] = v;
      list_id[pos-1]    = id;
    end
  endtask

  task automatic close_slide();
    slide_word_t w;
    for (int i = 0; i < list_fill; i++) begin
      w = '{value: list_value[i], id: list_id[i], last: (i == list_fill - 1)};
      pend_words[(pend_head + pend_count) % PEND_DEPTH] = w;
      pend_count++;
    end
    list_fill = 0;
  endtask

  always @(posedge clk) begin
    slide_word_t seen, due;
    if (!rst_n) begin
      list_fill    = 0;
      topk_setting = TOPK_RESET;
      pend_head    = 0;
      pend_count   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{value: out_value, id: out_id, last: out_last};
        if (pend_count == 0) begin
          $display("%0t: word with nothing expected: value %h id %h last %b",
                   $time, seen.value, seen.id, seen.last);
          mismatches++;
        end else begin
          due        = pend_words[pend_head];
          pend_head  = (pend_head + 1) % PEND_DEPTH;
          pend_count--;
          if (seen.value !== due.value) begin
            $display("%0t: value expected %h actual %h", $time, due.value, seen.value);
            mismatches++;
          end
          if (seen.id !== due.id) begin
            $display("%0t: id expected %h actual %h", $time, due.id, seen.id);
            mismatches++;
          end
          if (seen.last !== due.last) begin
            $display("%0t: last expected %b actual %b", $time, due.last, seen.last);
            mismatches++;
          end
        end
      end
      // action high closes the slide, low is a stream item
      if (in_valid && !in_stall) begin
        if (in_action) close_slide();
        else insert_item(in_item_value, in_item_id);
      end
      // a write lands after any word taken at the same edge
      if (cfg_we) topk_setting = cfg_wdata;
    end
    words_pending = pend_count;
  end

endmodule

// ===== tb/per_slide_topk_tracker_test.sv =====
// Top of the per-slide top-k tracker testbench: clock, reset, stimulus and verdict.
module per_slide_topk_tracker_test import pstk_pkg::*;;

  localparam int  CYCLE_LIMIT = 400000;
  localparam logic ACT_STREAM = 1'b0;
  localparam logic ACT_CLOSE  = 1'b1;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_action;
  logic signed [VAL_W-1:0] in_item_value;
  logic        [ID_W-1:0]  in_item_id;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_value;
  logic        [ID_W-1:0]  out_id;
  logic                    out_last;
  logic                    cfg_we;
  logic        [CFG_W-1:0] cfg_wdata;

  int mismatches;
  int words_pending;
  int cycle_count = 0;
  // While set, neither side idles: back-to-back words in and out.
  bit quiet;

  per_slide_topk_tracker DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_item_value (in_item_value),
    .in_item_id    (in_item_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_id        (out_id),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  topk_slide_checker slide_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_item_value (in_item_value),
    .in_item_id    (in_item_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_id        (out_id),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always #10 clk = ~clk;

  // Stop a hung run; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: before each word, hold stall high for a random number of cycles,
  // then lower it and wait for the word to go through.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 18);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Drop valid at the next falling edge; every pause on the input side goes through here.
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Present one word after a random gap and hold it until the block takes it.
  // Valid stays high on return, so the caller must either present the next
  // word or release the input at the following falling edge.
  task automatic push_word(input logic act, input logic signed [VAL_W-1:0] v,
                           input logic [ID_W-1:0] id);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    repeat (gap) release_input();
    @(negedge clk);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_item_value <= v;
    in_item_id    <= id;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic stream_item(input logic signed [VAL_W-1:0] v, input logic [ID_W-1:0] id);
    push_word(ACT_STREAM, v, id);
  endtask

  // Close the slide with a random payload, which the block must ignore.
  task automatic close_slide_word();
    push_word(ACT_CLOSE, $urandom, $urandom);
  endtask

  // Hold the sender until every expected word has come out, then let the
  // last stream item and any empty-slide close settle.
  task automatic drain_wait();
    release_input();
    while (words_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_topk(input logic [CFG_W-1:0] k);
    drain_wait();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mix full-range values, a narrow band near zero for plenty of ties,
  // and the extremes of the signed range.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6, 7: begin
        v = $urandom_range(0, 12);
        v = v - 6;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MIN;
          1: v = VAL_MIN + 1;
          2: v = -1;
          3: v = 0;
          4: v = VAL_MAX - 1;
          default: v = VAL_MAX;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    int                random_items;
    int                slides;
    int                count;
    int                span;
    logic [CFG_W-1:0]  k;

    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_STREAM;
    in_item_value = '0;
    in_item_id    = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    quiet         = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, k at its reset value of 8.
    // Empty slide: a close with nothing kept emits no word.
    close_slide_word();
    // Fewer than k items, extremes of value and id, tie kept in arrival order.
    stream_item(32'sh0001_8000, 32'd1);
    stream_item(VAL_MIN,        32'hFFFF_FFFF);
    stream_item(VAL_MAX,        32'h0000_0000);
    stream_item(-32'sd1,        32'd2);
    stream_item(32'sh0001_8000, 32'd3);
    stream_item(32'sd0,         32'd4);
    close_slide_word();

    // k of one: a value equal to the minimum is refused, a larger one replaces it.
    write_topk(6'd1);
    stream_item(32'sd5, 32'd10);
    stream_item(32'sd5, 32'd11);
    stream_item(32'sd9, 32'd12);
    close_slide_word();

    // A zero setting acts as one.
    write_topk(6'd0);
    stream_item(32'sd3, 32'd20);
    stream_item(32'sd2, 32'd21);
    close_slide_word();

    // Full list: a replacing item goes in ahead of an equal value.
    write_topk(6'd3);
    stream_item(32'sd1, 32'd30);
    stream_item(32'sd5, 32'd31);
    stream_item(32'sd9, 32'd32);
    stream_item(32'sd5, 32'd33);
    close_slide_word();

    // Random part: phases of one setting and a few slides each. A phase may
    // end with its last slide left open, so the next setting lands mid-slide.
    random_items = 0;
    while (random_items < 200) begin
      case ($urandom_range(0, 9))
        0:       k = 6'd0;
        1:       k = 6'd1;
        2:       k = 6'(MAX_K_DEF);
        3:       k = 6'd63;
        4:       k = 6'(MAX_K_DEF + 1);
        default: k = 6'($urandom_range(1, 12));
      endcase
      write_topk(k);
      span   = (int'(k) > 12) ? 40 : 3 * int'(k) + 3;
      slides = $urandom_range(1, 4);
      for (int s = 0; s < slides; s++) begin
        quiet = ($urandom_range(0, 4) == 0);
        count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, span);
        repeat (count) stream_item(pick_value(), $urandom);
        random_items += count;
        if (s + 1 < slides || $urandom_range(0, 3) != 0) begin
          close_slide_word();
          random_items++;
        end
        // Now and then hold the sender until the slide has fully drained.
        if ($urandom_range(0, 5) == 0) drain_wait();
      end
    end
    quiet = 1'b0;
    close_slide_word();

    // Wait for the last words, then allow the block a little longer to
    // show anything stray.
    drain_wait();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pstk_pkg.sv
hdl/pstk_cell.sv
hdl/per_slide_topk_tracker.sv
tb/topk_slide_checker.sv
tb/per_slide_topk_tracker_test.sv
